>>> hw/rtl/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform core.
package hpt_pkg;

    // Q16.16 format and datapath widths
    localparam int FRAC   = 16;
    localparam int CW     = 32;           // coordinate and coefficient width
    localparam int PW     = 2 * CW;       // product width, Q32.32
    localparam int SW     = PW + 2;       // four-term sum width
    localparam int NLANE  = 3;            // x, y, z
    localparam int NROW   = 4;
    localparam int NCOL   = 4;

    // Divider: quotient bits kept. Anything at or above 2^QW saturates anyway.
    localparam int NSH    = 17;
    localparam int QW     = NSH + FRAC;   // 33

    // Configuration register file
    localparam int NCFG   = 8;
    localparam int DW     = 64;
    localparam int AW     = 6;            // byte address, 8 bytes per register
    localparam int IDXW   = 3;

    // Queue between front and back
    localparam int QD     = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    localparam logic [PW-1:0] ONE_D   = 64'h0000_0001_0000_0000;
    localparam logic [31:0]   SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0]   SAT_NEG = 32'h8000_0000;

    localparam logic [NCFG-1:0][DW-1:0] CFG_RST = {
        64'h0001_0000_0000_0000,  // row3 cols23
        64'h0000_0000_0000_0000,  // row3 cols01
        64'h0000_0000_0001_0000,  // row2 cols23
        64'h0000_0000_0000_0000,  // row2 cols01
        64'h0000_0000_0000_0000,  // row1 cols23
        64'h0001_0000_0000_0000,  // row1 cols01
        64'h0000_0000_0000_0000,  // row0 cols23
        64'h0000_0000_0001_0000   // row0 cols01
    };

    // Matrix coefficients [row][col]
    typedef logic [NROW-1:0][NCOL-1:0][CW-1:0] t_mat;

    // Word passed from front to back through the queue
    typedef struct packed {
        logic [NLANE-1:0][PW-1:0] nmag;
        logic [NLANE-1:0]         neg;
        logic [PW-1:0]            d;
        logic                     wzero;
    } t_qent;

    // One divider lane between stages
    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QW-1:0] lo;
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
    } t_lane;

    typedef struct packed {
        t_lane [NLANE-1:0] lane;
        logic [PW-1:0]     d;
        logic              wzero;
    } t_bstg;

    // After rounding
    typedef struct packed {
        logic [NLANE-1:0][QW:0] q;
        logic [NLANE-1:0]       ovf;
        logic [NLANE-1:0]       neg;
        logic                   wzero;
    } t_rnd;

endpackage

>>> hw/rtl/homogeneous_point_transform_core.sv
// Top level: configuration register file, front end, queue and divider back end.
// One coordinate word is accepted per clock and one result word leaves per clock when the
// output is not stalled. A word passes three front stages (capture, 32x32 multiplies,
// exact sums), the four-entry queue, then a load stage, a 33-stage restoring divider
// that retires one quotient bit per stage, a rounding stage and the output register.
// Matrix registers sit at byte address 8*i on the 64-bit APB port and must only be written
// while no word is in flight.
module homogeneous_point_transform_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [hpt_pkg::AW-1:0]  paddr,
    input  logic [hpt_pkg::DW-1:0]  pwdata,
    output logic [hpt_pkg::DW-1:0]  prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_action,
    input  logic [31:0]             i_in_x,
    input  logic [31:0]             i_in_y,
    input  logic [31:0]             i_in_z,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [31:0]             o_out_x,
    output logic [31:0]             o_out_y,
    output logic [31:0]             o_out_z,
    output logic                    o_w_zero,
    output logic                    o_saturated
);

    logic [hpt_pkg::NCFG-1:0][hpt_pkg::DW-1:0] r_cfg;
    logic [hpt_pkg::IDXW-1:0] idx;
    hpt_pkg::t_mat   mat;
    hpt_pkg::t_qent  push_ent, pop_ent;
    logic            push, full, pop, avail;

    // Register file
    assign pready = 1'b1;
    assign idx    = paddr[hpt_pkg::AW-1:hpt_pkg::AW-hpt_pkg::IDXW];
    assign prdata = r_cfg[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= hpt_pkg::CFG_RST;
        end else if (psel && penable && pwrite && pready) begin
            r_cfg[idx] <= pwdata;
        end
    end

    // Unpack coefficients
    always_comb begin
        for (int r = 0; r < hpt_pkg::NROW; r++) begin
            mat[r][0] = r_cfg[2*r][31:0];
            mat[r][1] = r_cfg[2*r][63:32];
            mat[r][2] = r_cfg[2*r+1][31:0];
            mat[r][3] = r_cfg[2*r+1][63:32];
        end
    end

    hpt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mat      (mat),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_in_x     (i_in_x),
        .i_in_y     (i_in_y),
        .i_in_z     (i_in_z),
        .i_full     (full),
        .o_push     (push),
        .o_ent      (push_ent)
    );

    hpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_ent   (pop_ent)
    );

    hpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (avail),
        .i_ent       (pop_ent),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_w_zero    (o_w_zero),
        .o_saturated (o_saturated)
    );

endmodule

>>> hw/rtl/hpt_front.sv
// Front end: accepts words, forms the four row dot products and sign/magnitude.
module hpt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hpt_pkg::t_mat     i_mat,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [31:0]       i_in_x,
    input  logic [31:0]       i_in_y,
    input  logic [31:0]       i_in_z,
    input  logic              i_full,
    output logic              o_push,
    output hpt_pkg::t_qent    o_ent
);

    typedef struct packed {
        logic                                       point;
        logic [hpt_pkg::NLANE-1:0][hpt_pkg::CW-1:0] c;
    } t_f1;

    typedef struct packed {
        logic                                                            point;
        logic [hpt_pkg::NROW-1:0][hpt_pkg::NLANE-1:0][hpt_pkg::PW-1:0]   p;
        logic [hpt_pkg::NROW-1:0][hpt_pkg::PW-1:0]                       t;
    } t_f2;

    typedef struct packed {
        logic                                       point;
        logic [hpt_pkg::NROW-1:0][hpt_pkg::SW-1:0]  s;
    } t_f3;

    logic r_v1, r_v2, r_v3;
    t_f1  r_f1, n_f1;
    t_f2  r_f2, n_f2;
    t_f3  r_f3, n_f3;
    logic en;

    logic signed [hpt_pkg::CW-1:0] mx [hpt_pkg::NLANE];
    logic signed [hpt_pkg::CW-1:0] mc [hpt_pkg::NROW][hpt_pkg::NLANE];
    logic signed [hpt_pkg::PW-1:0] pr [hpt_pkg::NROW][hpt_pkg::NLANE];

    // Whole front moves unless the last word is blocked by a full queue
    assign en         = !(r_v3 && i_full);
    assign o_in_ready = en;
    assign o_push     = r_v3 && !i_full;

    // Stage 1: capture
    always_comb begin
        n_f1.point = !i_action;
        n_f1.c[0]  = i_in_x;
        n_f1.c[1]  = i_in_y;
        n_f1.c[2]  = i_in_z;
    end

    // Stage 2: products, translation column as a shift
    always_comb begin
        for (int k = 0; k < hpt_pkg::NLANE; k++) begin
            mx[k] = $signed(r_f1.c[k]);
        end
        for (int r = 0; r < hpt_pkg::NROW; r++) begin
            for (int k = 0; k < hpt_pkg::NLANE; k++) begin
                mc[r][k] = $signed(i_mat[r][k]);
                pr[r][k] = mx[k] * mc[r][k];
            end
        end
        n_f2.point = r_f1.point;
        for (int r = 0; r < hpt_pkg::NROW; r++) begin
            for (int k = 0; k < hpt_pkg::NLANE; k++) begin
                n_f2.p[r][k] = pr[r][k];
            end
            n_f2.t[r] = r_f1.point ?
                {{(hpt_pkg::PW-hpt_pkg::CW-hpt_pkg::FRAC){i_mat[r][3][hpt_pkg::CW-1]}},
                 i_mat[r][3], {hpt_pkg::FRAC{1'b0}}} : '0;
        end
    end

    // Stage 3: exact Q34.32 row sums
    always_comb begin
        n_f3.point = r_f2.point;
        for (int r = 0; r < hpt_pkg::NROW; r++) begin
            n_f3.s[r] = {{2{r_f2.p[r][0][hpt_pkg::PW-1]}}, r_f2.p[r][0]}
                      + {{2{r_f2.p[r][1][hpt_pkg::PW-1]}}, r_f2.p[r][1]}
                      + {{2{r_f2.p[r][2][hpt_pkg::PW-1]}}, r_f2.p[r][2]}
                      + {{2{r_f2.t[r][hpt_pkg::PW-1]}},    r_f2.t[r]};
        end
    end

    // Queue word: magnitudes, result signs and divisor
    always_comb begin
        logic                   wneg;
        logic [hpt_pkg::PW-1:0] wmag;
        wneg = r_f3.point && r_f3.s[3][hpt_pkg::SW-1];
        wmag = r_f3.s[3][hpt_pkg::SW-1] ? hpt_pkg::PW'(-r_f3.s[3]) : r_f3.s[3][hpt_pkg::PW-1:0];
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            o_ent.nmag[l] = r_f3.s[l][hpt_pkg::SW-1] ? hpt_pkg::PW'(-r_f3.s[l])
                                                     : r_f3.s[l][hpt_pkg::PW-1:0];
            o_ent.neg[l]  = (r_f3.s[l][hpt_pkg::SW-1] ^ wneg) && (r_f3.s[l] != '0);
        end
        o_ent.wzero = r_f3.point && (r_f3.s[3] == '0);
        o_ent.d     = r_f3.point ? wmag : hpt_pkg::ONE_D;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
        end
    end

endmodule

>>> hw/rtl/hpt_queue.sv
// Short FIFO that decouples the front end from the divider back end.
module hpt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hpt_pkg::t_qent  i_ent,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_avail,
    output hpt_pkg::t_qent  o_ent
);

    hpt_pkg::t_qent r_mem [hpt_pkg::QD];
    logic [hpt_pkg::QAW-1:0] r_wp, r_rp;
    logic [hpt_pkg::QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == hpt_pkg::QCW'(hpt_pkg::QD));
    assign o_avail = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_ent;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_avail)) else $error("queue pop while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hpt_pkg::QCW'(hpt_pkg::QD)) else $error("queue count out of range");

endmodule

>>> hw/rtl/hpt_back.sv
// Back end: pipelined restoring divider, rounding, saturation and output register.
module hpt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  hpt_pkg::t_qent  i_ent,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_out_x,
    output logic [31:0]     o_out_y,
    output logic [31:0]     o_out_z,
    output logic            o_w_zero,
    output logic            o_saturated
);

    logic                 r_bv [hpt_pkg::QW+1];
    hpt_pkg::t_bstg       r_bs [hpt_pkg::QW+1];
    hpt_pkg::t_bstg       n_bs [hpt_pkg::QW+1];
    logic                 r_rv;
    hpt_pkg::t_rnd        r_rd, n_rd;
    logic                 r_ov;
    logic [2:0][31:0]     r_o, n_o;
    logic                 r_wz, r_sat, n_sat;
    logic                 en;

    assign en          = !r_ov || i_out_ready;
    assign o_pop       = en && i_avail;
    assign o_out_valid = r_ov;
    assign o_out_x     = r_o[0];
    assign o_out_y     = r_o[1];
    assign o_out_z     = r_o[2];
    assign o_w_zero    = r_wz;
    assign o_saturated = r_sat;

    // Load stage and one quotient bit per stage
    always_comb begin
        logic [hpt_pkg::PW-1:0] nsh;
        logic [hpt_pkg::PW:0]   t;
        logic [hpt_pkg::PW:0]   df;
        logic                   ge;
        n_bs[0].d     = i_ent.d;
        n_bs[0].wzero = i_ent.wzero;
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            nsh = i_ent.nmag[l] >> hpt_pkg::NSH;
            n_bs[0].lane[l].rem = nsh;
            n_bs[0].lane[l].lo  = {i_ent.nmag[l][hpt_pkg::NSH-1:0], {hpt_pkg::FRAC{1'b0}}};
            n_bs[0].lane[l].q   = '0;
            n_bs[0].lane[l].ovf = (nsh >= i_ent.d);
            n_bs[0].lane[l].neg = i_ent.neg[l];
        end
        for (int k = 0; k < hpt_pkg::QW; k++) begin
            n_bs[k+1].d     = r_bs[k].d;
            n_bs[k+1].wzero = r_bs[k].wzero;
            for (int l = 0; l < hpt_pkg::NLANE; l++) begin
                t  = {r_bs[k].lane[l].rem, r_bs[k].lane[l].lo[hpt_pkg::QW-1]};
                df = t - {1'b0, r_bs[k].d};
                ge = (t >= {1'b0, r_bs[k].d});
                n_bs[k+1].lane[l].rem = ge ? df[hpt_pkg::PW-1:0] : t[hpt_pkg::PW-1:0];
                n_bs[k+1].lane[l].lo  = {r_bs[k].lane[l].lo[hpt_pkg::QW-2:0], 1'b0};
                n_bs[k+1].lane[l].q   = {r_bs[k].lane[l].q[hpt_pkg::QW-2:0], ge};
                n_bs[k+1].lane[l].ovf = r_bs[k].lane[l].ovf;
                n_bs[k+1].lane[l].neg = r_bs[k].lane[l].neg;
            end
        end
    end

    // Round to nearest, ties away from zero (on the magnitude)
    always_comb begin
        logic rnd;
        n_rd.wzero = r_bs[hpt_pkg::QW].wzero;
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            rnd = ({r_bs[hpt_pkg::QW].lane[l].rem, 1'b0} >= {1'b0, r_bs[hpt_pkg::QW].d});
            n_rd.q[l]   = {1'b0, r_bs[hpt_pkg::QW].lane[l].q} + (hpt_pkg::QW+1)'(rnd);
            n_rd.ovf[l] = r_bs[hpt_pkg::QW].lane[l].ovf;
            n_rd.neg[l] = r_bs[hpt_pkg::QW].lane[l].neg;
        end
    end

    // Sign, clamp, and zero-w override
    always_comb begin
        n_sat = 1'b0;
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            if (r_rd.wzero) begin
                n_o[l] = '0;
            end else if (r_rd.neg[l]) begin
                if (r_rd.ovf[l] || r_rd.q[l] > (hpt_pkg::QW+1)'(hpt_pkg::SAT_NEG)) begin
                    n_o[l] = hpt_pkg::SAT_NEG;
                    n_sat  = 1'b1;
                end else begin
                    n_o[l] = 32'(~r_rd.q[l][31:0] + 32'd1);
                end
            end else begin
                if (r_rd.ovf[l] || r_rd.q[l] > (hpt_pkg::QW+1)'(hpt_pkg::SAT_POS)) begin
                    n_o[l] = hpt_pkg::SAT_POS;
                    n_sat  = 1'b1;
                end else begin
                    n_o[l] = r_rd.q[l][31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= hpt_pkg::QW; k++) r_bv[k] <= 1'b0;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv[0] <= o_pop;
            for (int k = 0; k < hpt_pkg::QW; k++) r_bv[k+1] <= r_bv[k];
            r_rv <= r_bv[hpt_pkg::QW];
            r_ov <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= hpt_pkg::QW; k++) r_bs[k] <= n_bs[k];
            r_rd  <= n_rd;
            r_o   <= n_o;
            r_wz  <= r_rd.wzero;
            r_sat <= n_sat;
        end
    end

    a_wzero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_wz) |-> (r_o == '0 && !r_sat)) else $error("zero w word not cleared");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> (r_ov && $stable(r_o) && $stable(r_sat)))
        else $error("output word changed while stalled");
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !$isunknown({r_o, r_wz, r_sat})) else $error("output word has unknown bits");

endmodule

>>> verif/homogeneous_point_transform_core_checker.sv
// Checker for the point transform core: tracks the matrix registers, predicts and compares.
module homogeneous_point_transform_core_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [hpt_pkg::AW-1:0]  paddr,
    input  logic [hpt_pkg::DW-1:0]  pwdata,
    input  logic                    pready,
    input  logic                    i_in_valid,
    input  logic                    o_in_ready,
    input  logic                    i_action,
    input  logic [31:0]             i_in_x,
    input  logic [31:0]             i_in_y,
    input  logic [31:0]             i_in_z,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic [31:0]             o_out_x,
    input  logic [31:0]             o_out_y,
    input  logic [31:0]             o_out_z,
    input  logic                    o_w_zero,
    input  logic                    o_saturated,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_fails
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        wzero;
        logic        sat;
    } t_xform;

    logic [hpt_pkg::DW-1:0] matrix_regs [hpt_pkg::NCFG];
    t_xform                 expected_points [$];

    // Q16.16 coefficient (row, col) from the packed register pairs
    function automatic longint coef(int row, int col);
        logic [63:0] r;
        r = matrix_regs[row * 2 + col / 2];
        return longint'($signed(col % 2 ? r[63:32] : r[31:0]));
    endfunction

    // Exact transform, then round half away from zero and clamp to 32 bits
    function automatic t_xform transform_point(logic vec, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z);
        t_xform      res;
        t_wide       sums [4];
        longint      crd [3];
        logic [127:0] dmag, nmag, q, rem;
        logic        wneg, nneg, neg;
        crd[0] = longint'($signed(x));
        crd[1] = longint'($signed(y));
        crd[2] = longint'($signed(z));
        for (int r = 0; r < 4; r++) begin
            sums[r] = '0;
            for (int k = 0; k < 3; k++)
                sums[r] = sums[r] + t_wide'(crd[k] * coef(r, k));
            if (!vec)
                sums[r] = sums[r] + t_wide'(coef(r, 3) * 64'sd65536);
        end
        res.sat = 1'b0;
        res.wzero = 1'b0;
        if (!vec && sums[3] == 0) begin
            res.x = '0;
            res.y = '0;
            res.z = '0;
            res.wzero = 1'b1;
            return res;
        end
        wneg = !vec && sums[3] < 0;
        dmag = vec ? 128'h1_0000_0000 : (wneg ? -sums[3] : sums[3]);
        for (int k = 0; k < 3; k++) begin
            nneg = sums[k] < 0;
            nmag = nneg ? -sums[k] : sums[k];
            q = (nmag << 16) / dmag;
            rem = (nmag << 16) % dmag;
            if (rem >= dmag - rem)
                q = q + 1;
            neg = (nneg != wneg) && nmag != 0;
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    q = 128'h8000_0000;
                    res.sat = 1'b1;
                end
                q = -q;
            end else if (q > 128'h7FFF_FFFF) begin
                q = 128'h7FFF_FFFF;
                res.sat = 1'b1;
            end
            case (k)
                0: res.x = q[31:0];
                1: res.y = q[31:0];
                default: res.z = q[31:0];
            endcase
        end
        return res;
    endfunction

    initial o_pending = 0;

    // Watch register writes, input words and result words
    always @(posedge i_clk) begin
        t_xform e;
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::NCFG; i++)
                matrix_regs[i] = hpt_pkg::CFG_RST[i];
            expected_points.delete();
            o_checked = 0;
            o_fails = 0;
        end else begin
            if (psel && penable && pwrite && pready)
                matrix_regs[paddr[5:3]] = pwdata;
            if (i_in_valid && o_in_ready)
                expected_points.push_back(transform_point(i_action, i_in_x, i_in_y, i_in_z));
            if (o_out_valid && i_out_ready) begin
                o_checked++;
                if (expected_points.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fails++;
                end else begin
                    e = expected_points.pop_front();
                    if (o_out_x !== e.x) begin
                        $error("out_x expected %h got %h", e.x, o_out_x);
                        o_fails++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y expected %h got %h", e.y, o_out_y);
                        o_fails++;
                    end
                    if (o_out_z !== e.z) begin
                        $error("out_z expected %h got %h", e.z, o_out_z);
                        o_fails++;
                    end
                    if (o_w_zero !== e.wzero) begin
                        $error("w_zero expected %b got %b", e.wzero, o_w_zero);
                        o_fails++;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated expected %b got %b", e.sat, o_saturated);
                        o_fails++;
                    end
                end
            end
        end
        o_pending = expected_points.size();
    end
endmodule

>>> verif/homogeneous_point_transform_core_test.sv
// Testbench top for the point transform core: stimulus, register setup and verdict.
module homogeneous_point_transform_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_POINT  = 1'b0;
    localparam logic ACT_VECTOR = 1'b1;

    localparam int REG_ROW0_C01 = 0;
    localparam int REG_ROW0_C23 = 1;
    localparam int REG_ROW1_C01 = 2;
    localparam int REG_ROW1_C23 = 3;
    localparam int REG_ROW2_C01 = 4;
    localparam int REG_ROW2_C23 = 5;
    localparam int REG_ROW3_C01 = 6;
    localparam int REG_ROW3_C23 = 7;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 80;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [hpt_pkg::AW-1:0]  paddr = '0;
    logic [hpt_pkg::DW-1:0]  pwdata = '0;
    logic [hpt_pkg::DW-1:0]  prdata;
    logic                    pready;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_action = 1'b0;
    logic [31:0]             i_in_x = '0;
    logic [31:0]             i_in_y = '0;
    logic [31:0]             i_in_z = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [31:0]             o_out_x;
    logic [31:0]             o_out_y;
    logic [31:0]             o_out_z;
    logic                    o_w_zero;
    logic                    o_saturated;

    int pending, checked, fails;
    int cycles = 0;
    int words_sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    always #2 i_clk = ~i_clk;

    homogeneous_point_transform_core dut (.*);

    homogeneous_point_transform_core_checker u_checker (
        .*, .o_pending(pending), .o_checked(checked), .o_fails(fails)
    );

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("homogeneous_point_transform_core_test: FAIL");
            $finish;
        end
    end

    // Output backpressure: short stalls mostly, some long ones, none when calm
    always @(posedge i_clk) begin
        int r;
        int nxt;
        r = $urandom_range(99);
        nxt = stall_left;
        if (nxt > 0)
            nxt--;
        else if (!calm && r < 12)
            nxt = $urandom_range(1, 3);
        else if (!calm && r < 14)
            nxt = $urandom_range(15, 50);
        stall_left <= nxt;
        i_out_ready <= (nxt == 0);
    end

    // APB write: setup then access
    task automatic write_reg(int idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= hpt_pkg::AW'(idx * 8);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait for all results, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        // let the checker see the last accepted word first
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Present one coordinate word and hold it until accepted
    task automatic send_word(logic act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int r;
        int gap;
        r = $urandom_range(99);
        gap = calm ? 0 : (r < 70 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        logic [31:0] pick [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                                  32'hFFFF_FFFF, 32'h0001_0000};
        r = $urandom_range(9);
        if (r < 4)
            return $urandom;
        if (r < 7)
            return $urandom_range(0, 1) ? $urandom_range(0, 32'h40000)
                                        : -$urandom_range(0, 32'h40000);
        if (r < 8)
            return pick[$urandom_range(0, 5)];
        return $urandom_range(0, 1) ? $urandom_range(0, 32'h100_0000)
                                    : -$urandom_range(0, 32'h100_0000);
    endfunction

    // Small coefficient, within about +-4.0
    function automatic logic [31:0] small_coef();
        return $urandom_range(0, 1) ? $urandom_range(0, 32'h4_0000) : -$urandom_range(0, 32'h4_0000);
    endfunction

    task automatic random_words(int n, bit small_pts);
        logic [31:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0)
                calm = ($urandom_range(3) == 0);
            x = small_pts ? small_coef() : rand_coord();
            y = small_pts ? small_coef() : rand_coord();
            z = small_pts ? small_coef() : rand_coord();
            send_word($urandom_range(0, 3) == 0 ? ACT_VECTOR : ACT_POINT, x, y, z);
        end
        calm = 1'b0;
    endtask

    task automatic extremes_both_modes();
        send_word(ACT_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(ACT_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(ACT_VECTOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_word(ACT_VECTOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_POINT, 32'h0, 32'h0, 32'h0);
        send_word(ACT_POINT, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000);
    endtask

    initial begin
        logic [63:0] v;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset matrix: identity, w exactly one
        extremes_both_modes();
        random_words(250, 1'b0);
        drain();

        // Full-scale coefficients: saturation in both directions
        write_reg(REG_ROW0_C01, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_ROW0_C23, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(REG_ROW1_C01, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_ROW1_C23, 64'h8000_0000_8000_0000);
        write_reg(REG_ROW2_C01, 64'hFFFF_FFFF_0000_0001);
        write_reg(REG_ROW2_C23, 64'h0000_0000_0001_0000);
        write_reg(REG_ROW3_C01, 64'h0000_0000_0000_0000);
        write_reg(REG_ROW3_C23, 64'h0001_0000_0000_0000);
        extremes_both_modes();
        random_words(200, 1'b0);
        drain();

        // Projective row all zero: every point gives w of zero
        write_reg(REG_ROW3_C01, 64'h0);
        write_reg(REG_ROW3_C23, 64'h0);
        extremes_both_modes();
        random_words(120, 1'b0);
        drain();

        // Small random projective matrices: real divides, w near zero now and then
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < hpt_pkg::NCFG; i++)
                write_reg(i, {small_coef(), small_coef()});
            random_words(150, 1'b1);
            random_words(40, 1'b0);
            drain();
        end

        // Fully random register contents
        for (int ph = 0; ph < 2; ph++) begin
            for (int i = 0; i < hpt_pkg::NCFG; i++) begin
                v = {$urandom, $urandom};
                write_reg(i, v);
            end
            random_words(100, 1'b0);
            drain();
        end

        // All ones: every coefficient is the smallest negative step
        for (int i = 0; i < hpt_pkg::NCFG; i++)
            write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
        extremes_both_modes();
        random_words(100, 1'b0);
        drain();

        $display("Sent %0d coordinate words over identity, full-scale, zero-w, projective,",
                 words_sent);
        $display("random and all-ones matrices; %0d results checked.", checked);
        if (fails == 0) begin
            $display("homogeneous_point_transform_core_test: PASS");
        end else begin
            $display("homogeneous_point_transform_core_test: FAIL");
        end
        $finish;
    end
endmodule
